[design/lbct_pkg.sv]
package lbct_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int TAG_W   = 20;
	localparam int STAMP_W = 64;

	// access commands
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;
	localparam logic [1:0] CMD_INVAL = 2'd3;

	typedef struct packed {
		logic [1:0]       command;
		logic [TAG_W-1:0] block_tag;
	} lbct_req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              writeback;
		logic [TAG_W-1:0]  victim_tag;
		logic              fill;
		logic              last;
	} lbct_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic flush_start;
		logic lookup;
		logic scan;
		logic emit_access;
		logic emit_flush;
	} lbct_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic scan_last;
		logic flush_last;
	} lbct_sts_t;

endpackage

[design/lbct_ctrl.sv]
module lbct_ctrl
	import lbct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  logic [1:0] req_command,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output lbct_ctl_t ctl,
	input  lbct_sts_t sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOKUP = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_RESULT = 3'd3;
	localparam logic [2:0] ST_FLUSH  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;
	logic       emit;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign emit      = ctl.emit_access || ctl.emit_flush;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req_command)
						CMD_INVAL: ctl.clear = 1'b1;
						CMD_FLUSH: begin
							ctl.flush_start = 1'b1;
							state_d         = ST_FLUSH;
						end
						default: begin
							ctl.load = 1'b1;
							state_d  = ST_LOOKUP;
						end
					endcase
				end
			end
			ST_LOOKUP: begin
				ctl.lookup = 1'b1;
				state_d    = sts.hit ? ST_RESULT : ST_SCAN;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					ctl.emit_access = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					ctl.emit_flush = 1'b1;
					if (sts.flush_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= emit || (rsp_valid_q && rsp_stall);
		end
	end

endmodule

[design/lbct_datapath.sv]
module lbct_datapath
	import lbct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lbct_req_t req,
	input  lbct_ctl_t ctl,
	output lbct_sts_t sts,
	output lbct_rsp_t rsp
);

	function automatic logic [SLOT_W-1:0] lowest_idx(input logic [SLOTS-1:0] v);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

	logic [SLOTS-1:0]   valid_q;
	logic [SLOTS-1:0]   dirty_q;
	logic [STAMP_W-1:0] counter_q;
	logic [TAG_W-1:0]   tag_q [SLOTS];
	logic [STAMP_W-1:0] stamp_q [SLOTS];

	logic               wr_q;
	logic [TAG_W-1:0]   acc_tag_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  hit_idx_q;
	logic [SLOT_W-1:0]  scan_idx_q;
	logic [STAMP_W-1:0] best_q;
	logic [SLOT_W-1:0]  best_idx_q;
	logic [SLOTS-1:0]   pend_q;
	lbct_rsp_t          rsp_q;

	logic [SLOTS-1:0]   match;
	logic [SLOTS-1:0]   pend_low;
	logic [SLOTS-1:0]   pend_rest;
	logic [SLOT_W-1:0]  flush_idx;
	logic [SLOT_W-1:0]  rd_idx;
	logic [TAG_W-1:0]   rd_tag;
	logic [STAMP_W-1:0] cand;
	logic [STAMP_W-1:0] stamp0;
	logic [STAMP_W-1:0] next_count;
	logic               victim_wb;

	// parallel tag compare against every resident slot
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = valid_q[i] && (tag_q[i] == acc_tag_q);
		end
	end

	// an empty slot counts as stamp zero
	assign cand   = valid_q[scan_idx_q] ? stamp_q[scan_idx_q] : '0;
	assign stamp0 = valid_q[0] ? stamp_q[0] : '0;

	assign pend_low   = pend_q & (~pend_q + SLOTS'(1));
	assign pend_rest  = pend_q & ~pend_low;
	assign flush_idx  = lowest_idx(pend_q);
	assign rd_idx     = ctl.emit_flush ? flush_idx : best_idx_q;
	assign rd_tag     = tag_q[rd_idx];
	assign next_count = counter_q + STAMP_W'(1);
	assign victim_wb  = valid_q[best_idx_q] && dirty_q[best_idx_q];

	assign sts.hit        = |match;
	assign sts.scan_last  = (scan_idx_q == SLOT_W'(SLOTS - 1));
	assign sts.flush_last = (pend_rest == '0);
	assign rsp            = rsp_q;

	// slot state with reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			dirty_q   <= '0;
			counter_q <= '0;
		end else begin
			if (ctl.clear) begin
				valid_q   <= '0;
				dirty_q   <= '0;
				counter_q <= '0;
			end
			if (ctl.emit_access) begin
				counter_q <= next_count;
				if (hit_q) begin
					if (wr_q) begin
						dirty_q[hit_idx_q] <= 1'b1;
					end
				end else begin
					valid_q[best_idx_q] <= 1'b1;
					dirty_q[best_idx_q] <= wr_q;
				end
			end
			if (ctl.emit_flush && (pend_q != '0)) begin
				dirty_q[flush_idx] <= 1'b0;
			end
		end
	end

	// tags, stamps and working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			wr_q      <= (req.command == CMD_WRITE);
			acc_tag_q <= req.block_tag;
		end
		if (ctl.flush_start) begin
			pend_q <= valid_q & dirty_q;
		end
		if (ctl.lookup) begin
			hit_q      <= |match;
			hit_idx_q  <= lowest_idx(match);
			best_q     <= stamp0;
			best_idx_q <= '0;
			scan_idx_q <= SLOT_W'(1);
		end
		if (ctl.scan) begin
			scan_idx_q <= scan_idx_q + SLOT_W'(1);
			if (cand < best_q) begin
				best_q     <= cand;
				best_idx_q <= scan_idx_q;
			end
		end
		if (ctl.emit_access) begin
			if (hit_q) begin
				stamp_q[hit_idx_q] <= next_count;
				rsp_q.hit        <= 1'b1;
				rsp_q.slot       <= hit_idx_q;
				rsp_q.writeback  <= 1'b0;
				rsp_q.victim_tag <= '0;
				rsp_q.fill       <= 1'b0;
			end else begin
				stamp_q[best_idx_q] <= next_count;
				tag_q[best_idx_q]   <= acc_tag_q;
				rsp_q.hit        <= 1'b0;
				rsp_q.slot       <= best_idx_q;
				rsp_q.writeback  <= victim_wb;
				rsp_q.victim_tag <= victim_wb ? rd_tag : '0;
				rsp_q.fill       <= 1'b1;
			end
			rsp_q.last <= 1'b1;
		end
		if (ctl.emit_flush) begin
			pend_q           <= pend_rest;
			rsp_q.hit        <= 1'b0;
			rsp_q.fill       <= 1'b0;
			rsp_q.last       <= (pend_rest == '0);
			if (pend_q != '0) begin
				rsp_q.slot       <= flush_idx;
				rsp_q.writeback  <= 1'b1;
				rsp_q.victim_tag <= rd_tag;
			end else begin
				rsp_q.slot       <= '0;
				rsp_q.writeback  <= 1'b0;
				rsp_q.victim_tag <= '0;
			end
		end
	end

endmodule

[design/lru_block_cache_tags.sv]
// channel | direction | handshake            | item
// req     | in        | req_valid, req_stall | lbct_req_t: command, block_tag
// rsp     | out       | rsp_valid, rsp_stall | lbct_rsp_t: hit, slot, writeback,
//         |           |                      |   victim_tag, fill, last
//
// one item is in work at a time; req_stall is high until it is done
// hit: accept, tag compare, result; miss: accept, tag compare, then the result
// after a serial scan of the use stamps for the smallest one
// flush: accept, then one result per dirty slot, one empty one if none; invalidate: at accept
// reset clears valid, dirty and the use counter; empty slots read as stamp zero
// rsp_stall holds the result register and the controller, no result is lost
module lru_block_cache_tags
	import lbct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  lbct_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output lbct_rsp_t rsp
);

	// command strobes and status between controller and datapath
	lbct_ctl_t ctl;
	lbct_sts_t sts;

	// sequencer: accept, lookup, stamp scan, result, flush walk
	lbct_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_command (req.command),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.ctl         (ctl),
		.sts         (sts)
	);

	// tag, valid, dirty, stamp store plus result register
	lbct_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

[bench/tb_lru_block_cache_tags.sv]
module tb_lru_block_cache_tags
	import lbct_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// mirror of the tag store: valid, tag, dirty and use stamp per slot,
	// plus the queue of slot reports that the block still owes
	class cache_tag_mirror;
		logic               valid_q [SLOTS];
		logic [TAG_W-1:0]   tag_q   [SLOTS];
		logic               dirty_q [SLOTS];
		logic [STAMP_W-1:0] stamp_q [SLOTS];
		logic [STAMP_W-1:0] use_count;
		lbct_rsp_t          owed_rsp [$];
		int                 errors;
		int                 checked;

		function new();
			clear_all();
			errors = 0;
			checked = 0;
		endfunction

		function void clear_all();
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] = 1'b0;
				tag_q[i]   = '0;
				dirty_q[i] = 1'b0;
				stamp_q[i] = '0;
			end
			use_count = '0;
		endfunction

		// work out the slot reports that one accepted item causes
		function void apply_command(lbct_req_t item);
			lbct_rsp_t r;
			int        victim;
			int        n_dirty;
			int        k;
			logic      found;
			r = '0;
			victim = 0;
			found = 1'b0;
			case (item.command)
				CMD_INVAL: begin
					clear_all();
				end
				CMD_FLUSH: begin
					n_dirty = 0;
					for (int i = 0; i < SLOTS; i++)
						if (valid_q[i] && dirty_q[i])
							n_dirty++;
					if (n_dirty == 0) begin
						// nothing dirty: one empty report
						r.last = 1'b1;
						owed_rsp.push_back(r);
					end else begin
						k = 0;
						for (int i = 0; i < SLOTS; i++) begin
							if (valid_q[i] && dirty_q[i]) begin
								r = '0;
								r.slot       = SLOT_W'(i);
								r.writeback  = 1'b1;
								r.victim_tag = tag_q[i];
								r.last       = (k == n_dirty - 1);
								owed_rsp.push_back(r);
								dirty_q[i] = 1'b0;
								k++;
							end
						end
					end
				end
				default: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (!found && valid_q[i] && tag_q[i] == item.block_tag) begin
							found = 1'b1;
							victim = i;
						end
					end
					use_count = use_count + 1'b1;
					r.last = 1'b1;
					if (found) begin
						stamp_q[victim] = use_count;
						if (item.command == CMD_WRITE)
							dirty_q[victim] = 1'b1;
						r.hit = 1'b1;
					end else begin
						// least recent stamp, lowest slot on ties
						for (int i = 1; i < SLOTS; i++)
							if (stamp_q[i] < stamp_q[victim])
								victim = i;
						if (valid_q[victim] && dirty_q[victim]) begin
							r.writeback  = 1'b1;
							r.victim_tag = tag_q[victim];
						end
						valid_q[victim] = 1'b1;
						tag_q[victim]   = item.block_tag;
						dirty_q[victim] = (item.command == CMD_WRITE);
						stamp_q[victim] = use_count;
						r.fill = 1'b1;
					end
					r.slot = SLOT_W'(victim);
					owed_rsp.push_back(r);
				end
			endcase
		endfunction

		function int pending();
			return owed_rsp.size();
		endfunction

		task report_mismatch(string what);
			$display("mismatch at report %0d: %s", checked, what);
			errors++;
		endtask

		task match_report(lbct_rsp_t got);
			lbct_rsp_t want;
			checked++;
			if (owed_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected report slot %0d wb %0b tag %h",
					got.slot, got.writeback, got.victim_tag));
				return;
			end
			want = owed_rsp.pop_front();
			if (got.hit !== want.hit)
				report_mismatch($sformatf("hit %b want %b", got.hit, want.hit));
			if (got.slot !== want.slot)
				report_mismatch($sformatf("slot %0d want %0d", got.slot, want.slot));
			if (got.writeback !== want.writeback)
				report_mismatch($sformatf("writeback %b want %b", got.writeback,
					want.writeback));
			if (got.victim_tag !== want.victim_tag)
				report_mismatch($sformatf("victim_tag %h want %h", got.victim_tag,
					want.victim_tag));
			if (got.fill !== want.fill)
				report_mismatch($sformatf("fill %b want %b", got.fill, want.fill));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b want %b", got.last, want.last));
		endtask

		task report_leftovers();
			while (owed_rsp.size() != 0) begin
				report_mismatch($sformatf("report for slot %0d never came",
					owed_rsp[0].slot));
				void'(owed_rsp.pop_front());
			end
		endtask
	endclass

	typedef enum int {STALL_NONE, STALL_SPRINKLE, STALL_LONG} stall_mode_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	lbct_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	lbct_rsp_t rsp;

	cache_tag_mirror board;
	int              burst_left;

	lru_block_cache_tags uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

	// pick the next burst: mostly short, now and then a long run with no gaps
	function automatic int next_burst();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(20, 40);
		return $urandom_range(1, 8);
	endfunction

	// offer one item, hold it until accepted, then maybe idle for a gap
	task automatic send_cmd(input logic [1:0] cmd, input logic [TAG_W-1:0] tag);
		lbct_req_t item;
		item.command   = cmd;
		item.block_tag = tag;
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		board.apply_command(item);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// gap: valid low for a while, payload left alone
			req_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 6))
				@(posedge clk);
			burst_left = next_burst();
		end
	endtask

	// receiver: checks every accepted report and stalls on its own pattern
	initial begin
		stall_mode_t mode;
		int          mode_left;
		int          hold;
		rsp_stall <= 1'b0;
		mode = STALL_NONE;
		mode_left = 40;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid === 1'b1 && !rsp_stall)
				board.match_report(rsp);
			if (mode_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			if (hold > 0) begin
				hold--;
				rsp_stall <= 1'b1;
			end else begin
				case (mode)
					STALL_NONE: rsp_stall <= 1'b0;
					STALL_SPRINKLE: rsp_stall <= ($urandom_range(0, 2) == 0);
					default: begin
						// long stalls: now and then rsp_stall is held high by the hold counter
						if ($urandom_range(0, 5) == 0) begin
							hold = $urandom_range(1, 11);
							rsp_stall <= 1'b1;
						end else begin
							rsp_stall <= 1'b0;
						end
					end
				endcase
			end
		end
	end

	// stimulus
	initial begin
		logic [TAG_W-1:0] pool [20];
		logic [TAG_W-1:0] tag;
		logic [1:0]       cmd;
		int               pool_span;
		int               roll;
		int               waited;
		board = new();
		req_valid <= 1'b0;
		req       <= '0;
		arst_n    <= 1'b0;
		burst_left = next_burst();
		for (int i = 0; i < 20; i++)
			pool[i] = TAG_W'($urandom);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: flush of an empty store gives one empty report
		send_cmd(CMD_FLUSH, TAG_W'($urandom));
		// miss into an empty slot, then a hit on the same tag
		send_cmd(CMD_READ, '0);
		send_cmd(CMD_READ, '0);
		// write miss with the top tag, then write hit marks slot dirty
		send_cmd(CMD_WRITE, {TAG_W{1'b1}});
		send_cmd(CMD_WRITE, '0);
		// invalidate wipes everything, including the use counter
		send_cmd(CMD_INVAL, TAG_W'($urandom));
		// fill every slot dirty, in slot order
		for (int i = 0; i < SLOTS; i++) begin
			if (i == 0)
				tag = '0;
			else if (i == SLOTS - 1)
				tag = {TAG_W{1'b1}};
			else
				tag = {4'(i), 16'($urandom)};
			send_cmd(CMD_WRITE, tag);
		end
		// miss on a full store evicts the oldest dirty slot
		send_cmd(CMD_READ, 20'h5a5a5);
		// flush with many dirty slots, then again with none
		send_cmd(CMD_FLUSH, TAG_W'($urandom));
		send_cmd(CMD_FLUSH, TAG_W'($urandom));

		// random: tags mostly from a small pool so hits and evictions both occur
		pool_span = 20;
		for (int n = 0; n < 260; n++) begin
			if (n % 40 == 0) begin
				roll = $urandom_range(0, 2);
				pool_span = (roll == 0) ? 6 : (roll == 1) ? 17 : 20;
			end
			roll = $urandom_range(0, 99);
			if (roll < 42)
				cmd = CMD_READ;
			else if (roll < 84)
				cmd = CMD_WRITE;
			else if (roll < 96)
				cmd = CMD_FLUSH;
			else
				cmd = CMD_INVAL;
			if ($urandom_range(0, 9) == 0)
				tag = TAG_W'($urandom);
			else
				tag = pool[$urandom_range(0, pool_span - 1)];
			send_cmd(cmd, tag);
		end
		req_valid <= 1'b0;

		// drain outstanding reports, then let the block settle
		waited = 0;
		while (board.pending() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SLOTS * 2) @(posedge clk);
		board.report_leftovers();
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
design/lbct_pkg.sv
design/lbct_ctrl.sv
design/lbct_datapath.sv
design/lru_block_cache_tags.sv
bench/tb_lru_block_cache_tags.sv
